@@ rtl/b64e_pkg.sv @@
// Package: shared types, constants and the base64 alphabet function for the encoder.
`default_nettype none
package b64e_pkg;

  // Default depth of the group queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // ASCII pad character
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // One raw message byte request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } b64e_in_t;

  // One encoded character
  typedef struct packed {
    logic [7:0] code_char;
    logic       run_end;
    logic       message_end;
  } b64e_out_t;

  // A closed group of one to three bytes, left aligned
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  count;
    logic        last;
  } b64e_group_t;

  // Map a six-bit value onto the standard alphabet
  function automatic logic [7:0] b64e_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return 8'h41 + w;
    end else if (v < 6'd52) begin
      return 8'h61 + (w - 8'd26);
    end else if (v < 6'd62) begin
      return 8'h30 + (w - 8'd52);
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/b64e_front.sv @@
// Front part: gathers message bytes and closes groups of up to three bytes.
`default_nettype none
module b64e_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  byte_valid,
  output logic                 byte_stall,
  input  b64e_pkg::b64e_in_t   byte_data,
  output logic                 push,
  output b64e_pkg::b64e_group_t group,
  input  wire                  full
);
  import b64e_pkg::*;

  logic [15:0] pending_bytes, pending_bytes_next;
  logic [1:0]  pending_count, pending_count_next;
  logic [1:0]  held;
  logic [1:0]  n;
  logic        accept;

  // Stall while the queue has no room
  assign byte_stall = full;
  assign accept     = byte_valid && !full;

  // Classify the request and form the group
  always_comb begin
    held = (pending_count == 2'd3) ? 2'd2 : pending_count;
    n    = held + 2'd1;
    push = accept && (n == 2'd3 || byte_data.final_byte);
    pending_bytes_next = pending_bytes;
    pending_count_next = pending_count;
    group.count = n;
    group.last  = byte_data.final_byte;
    case (n)
      2'd3:    group.bits = {pending_bytes, byte_data.data_byte};
      2'd2:    group.bits = {pending_bytes[7:0], byte_data.data_byte, 8'h00};
      default: group.bits = {byte_data.data_byte, 16'h0000};
    endcase
    if (accept) begin
      if (push) begin
        pending_bytes_next = '0;
        pending_count_next = '0;
      end else begin
        pending_bytes_next = {pending_bytes[7:0], byte_data.data_byte};
        pending_count_next = n;
      end
    end
  end

  // Hold the open group
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bytes <= '0;
      pending_count <= '0;
    end else begin
      pending_bytes <= pending_bytes_next;
      pending_count <= pending_count_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/b64e_queue.sv @@
// Short queue of closed groups between front and back.
`default_nettype none
module b64e_queue #(
  parameter int Depth = b64e_pkg::QUEUE_DEPTH
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  b64e_pkg::b64e_group_t push_data,
  input  wire                   pop,
  output b64e_pkg::b64e_group_t head,
  output logic                  full,
  output logic                  empty
);
  import b64e_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  b64e_group_t          entries [Depth];
  logic [PtrW-1:0]      wr_ptr, rd_ptr;
  logic [CntW-1:0]      count;

  assign full  = (count == CntW'(Depth));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Store pushed groups
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/b64e_back.sv @@
// Back part: turns each queued group into four characters, one per cycle while the output is not stalled.
`default_nettype none
module b64e_back (
  input  wire                   clk,
  input  wire                   rst,
  input  b64e_pkg::b64e_group_t head,
  input  wire                   empty,
  output logic                  pop,
  output logic                  char_valid,
  input  wire                   char_stall,
  output b64e_pkg::b64e_out_t   char_data
);
  import b64e_pkg::*;

  logic [1:0]  idx;
  logic        load;
  logic [5:0]  sextet;
  logic        pad;
  b64e_out_t   char_next;

  // Load the output register whenever a group is queued and the register is free or being taken
  assign load = !empty && (!char_valid || !char_stall);
  assign pop  = load && (idx == 2'd3);

  // Select the sextet and decide on padding
  always_comb begin
    unique case (idx)
      2'd0: sextet = head.bits[23:18];
      2'd1: sextet = head.bits[17:12];
      2'd2: sextet = head.bits[11:6];
      2'd3: sextet = head.bits[5:0];
    endcase
    pad = ((idx == 2'd2) && (head.count == 2'd1)) ||
          ((idx == 2'd3) && (head.count != 2'd3));
    char_next.code_char   = pad ? PAD_CHAR : b64e_char(sextet);
    char_next.run_end     = (idx == 2'd3);
    char_next.message_end = (idx == 2'd3) && head.last;
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      char_data <= char_next;
    end
  end

  // Character index and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      char_valid <= 1'b0;
    end else begin
      if (load) begin
        idx        <= idx + 2'd1;
        char_valid <= 1'b1;
      end else if (!char_stall) begin
        char_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/base64_encoder.sv @@
// Top level: streaming base64 encoder with decoupled byte intake and character output.
`default_nettype none
// Streaming base64 encoder (standard alphabet, '=' padding). Message bytes
// come in one per request, the last one flagged final_byte. The front takes
// a byte in every cycle while the group queue has room, and closes a group on
// every third byte or on the final byte; the back sends four characters per
// group, one per cycle while char_stall is low, from a registered output.
// Sustained throughput is set by the single character output. A closing byte
// is written into the group queue, and its first character is then loaded
// into the output register once that register is free.
// run_end marks the fourth character of each group, message_end the fourth
// character of the final group.
module base64_encoder #(
  parameter int QueueDepth = b64e_pkg::QUEUE_DEPTH
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  byte_valid,
  output logic                 byte_stall,
  input  b64e_pkg::b64e_in_t   byte_data,
  output logic                 char_valid,
  input  wire                  char_stall,
  output b64e_pkg::b64e_out_t  char_data
);
  import b64e_pkg::*;

  b64e_group_t group, head;
  logic        push, pop, full, empty;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .push       (push),
    .group      (group),
    .full       (full)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (group),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data)
  );

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the streaming base64 encoder, with random idling on both channels.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import b64e_pkg::*;

  localparam int BYTE_TARGET = 260;
  localparam int DRAIN_CYCLES = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  b64e_in_t  byte_data = '0;
  logic      char_valid;
  logic      char_stall = 1'b0;
  b64e_out_t char_data;

  // Requests waiting to be driven, and characters the encoder owes us
  b64e_in_t  pending_reqs[$];
  b64e_out_t owed_chars[$];

  // Predictor state: bytes of the open group, newest in the low byte
  logic [15:0] open_bytes = '0;
  int          open_count = 0;

  int        mismatches = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        idle_cycles = 0;
  bit        src_quiet = 1'b0;
  bit        sink_quiet = 1'b0;
  b64e_in_t  next_req;
  b64e_out_t want;

  base64_encoder DUT (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_data (byte_data),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_data (char_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] sextet_ascii(input logic [5:0] v);
    return B64_ALPHABET[8*(63 - int'(v)) +: 8];
  endfunction

  // Work out the characters a request releases and queue them
  task automatic encode_request(input b64e_in_t req);
    logic [23:0] group;
    b64e_out_t   ch;
    int          n;
    n = open_count + 1;
    if (n < 3 && !req.final_byte) begin
      open_bytes = {open_bytes[7:0], req.data_byte};
      open_count = n;
    end else begin
      case (n)
        3:       group = {open_bytes, req.data_byte};
        2:       group = {open_bytes[7:0], req.data_byte, 8'h00};
        default: group = {req.data_byte, 16'h0000};
      endcase
      for (int k = 0; k < 4; k++) begin
        ch.code_char   = (k > n) ? PAD_CHAR : sextet_ascii(group[23 - 6*k -: 6]);
        ch.run_end     = (k == 3);
        ch.message_end = (k == 3) && req.final_byte;
        owed_chars.push_back(ch);
      end
      open_bytes = '0;
      open_count = 0;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Idle length: mostly short, now and then long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 90) return $urandom_range(2, 4);
    if (r < 98) return $urandom_range(5, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
    if (src_quiet || $urandom_range(0, 1) == 0) return 0;
    return pick_idle();
  endfunction

  task automatic queue_req(input logic [7:0] b, input logic fin);
    b64e_in_t req;
    req.data_byte  = b;
    req.final_byte = fin;
    pending_reqs.push_back(req);
  endtask

  // Driver: present the next request once the previous one has gone
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || !byte_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        byte_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        encode_request(next_req);
        byte_data  <= next_req;
        byte_valid <= 1'b1;
        gap_left = pick_gap();
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted character, then decide the next stall
  always @(posedge clk) begin
    if (rst) begin
      char_stall <= 1'b0;
    end else begin
      if (char_valid && !char_stall) begin
        if (owed_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character %h", char_data));
        end else begin
          want = owed_chars.pop_front();
          if (char_data.code_char !== want.code_char)
            report_mismatch($sformatf("code_char %h, want %h",
                                      char_data.code_char, want.code_char));
          if (char_data.run_end !== want.run_end)
            report_mismatch($sformatf("run_end %b, want %b",
                                      char_data.run_end, want.run_end));
          if (char_data.message_end !== want.message_end)
            report_mismatch($sformatf("message_end %b, want %b",
                                      char_data.message_end, want.message_end));
        end
      end
      if ($urandom_range(0, 59) == 0) sink_quiet = !sink_quiet;
      if (stall_left > 0) begin
        stall_left--;
        char_stall <= 1'b1;
      end else if (!sink_quiet && $urandom_range(0, 99) < 30) begin
        stall_left = pick_idle() - 1;
        char_stall <= 1'b1;
      end else begin
        char_stall <= 1'b0;
      end
    end
  end

  // Watchdog: give up when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (char_valid && !char_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int total;
    int len;

    // Directed: single-byte and two-byte finals with extreme values
    queue_req(8'h00, 1'b1);
    queue_req(8'hFF, 1'b1);
    queue_req(8'hFF, 1'b0);
    queue_req(8'h00, 1'b1);
    queue_req(8'h00, 1'b0);
    queue_req(8'hFF, 1'b1);
    // Full group giving alphabet entry 62 ('+') in every position
    queue_req(8'hFB, 1'b0);
    queue_req(8'hEF, 1'b0);
    queue_req(8'hBE, 1'b1);
    // Group closed by its third byte before the final group
    queue_req(8'hFF, 1'b0);
    queue_req(8'hFF, 1'b0);
    queue_req(8'hFF, 1'b0);
    queue_req(8'h00, 1'b0);
    queue_req(8'h00, 1'b0);
    queue_req(8'h00, 1'b1);
    // Full group with a one-byte remainder, then a full group with a two-byte remainder
    queue_req(8'hFF, 1'b0);
    queue_req(8'hFF, 1'b0);
    queue_req(8'hFF, 1'b0);
    queue_req(8'h00, 1'b1);
    queue_req(8'h12, 1'b0);
    queue_req(8'h34, 1'b0);
    queue_req(8'h56, 1'b0);
    queue_req(8'h78, 1'b0);
    queue_req(8'h9A, 1'b1);
    total = pending_reqs.size();

    // Random messages: mostly short, a few long
    while (total < BYTE_TARGET) begin
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
      for (int i = 0; i < len; i++)
        queue_req(8'($urandom_range(0, 255)), i == len - 1);
      total += len;
    end

    // Hold reset, then release
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Drain: wait for the last request and every owed character
    while (pending_reqs.size() != 0 || byte_valid || owed_chars.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_encoder.sv
sim/tb_top.sv
